// File: hw/rtl/atmu_pkg.sv
// ----------------------------------------------------------------------------
// atmu_pkg
// Shared types, codes, constants and tables of the affine transform unit.
// ----------------------------------------------------------------------------
package atmu_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS      = 30;
   localparam int ROT_STEPS         = 18;

   localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
   localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
   localparam logic signed [33:0] Q30_TWO_PI   = 34'sd6746518852;
   localparam logic signed [33:0] Q30_GAIN_INV = 34'sd652032874;
   localparam logic [32:0]        TWO_PI_MAG   = 33'd6746518852;

   typedef enum logic [2:0] {
      ACT_RESET     = 3'd0,
      ACT_SCALE     = 3'd1,
      ACT_TRANSLATE = 3'd2,
      ACT_ROTATE    = 3'd3,
      ACT_LOAD_ROW  = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE, S_IDENT, S_SCALE, S_TRANS, S_LOAD, S_RED_INIT, S_RED,
      S_CORDIC_INIT, S_CORDIC, S_CORDIC_FIN, S_ROT_MUL, S_ROT_ACC,
      S_PM_MUL, S_PM_ACC, S_PM_ROW, S_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CAPTURE, OP_IDENT, OP_SCALE, OP_TRANS, OP_LOAD_ROW,
      OP_RED_INIT, OP_RED_STEP, OP_CORDIC_INIT, OP_CORDIC_STEP, OP_CORDIC_FIN,
      OP_MUL, OP_ACC, OP_ROW_WRITE, OP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] step;
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] k;
      logic       use_op;
      logic       rot;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   typedef enum logic [2:0] {SEL_T, SEL_TX, SEL_TY, SEL_TZ, SEL_S} a_sel_type;
   typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z} b_sel_type;

   localparam logic [4:0] DEST_TX = 5'd16;
   localparam logic [4:0] DEST_TY = 5'd17;
   localparam logic [4:0] DEST_TZ = 5'd18;

   typedef struct packed {
      a_sel_type  a;
      b_sel_type  b;
      logic       neg;
      logic       first;
      logic       last;
      logic       add_c;
      logic [4:0] dest;
   } rot_op_type;

   // rotation matrix terms: t*u, then t*u*v +/- s*w or t*u*u + c
   function automatic rot_op_type rot_op(input logic [4:0] step);
      rot_op_type o;
      case (step)
         5'd0:    o = '{SEL_T,  SEL_X, 1'b0, 1'b1, 1'b1, 1'b0, DEST_TX};
         5'd1:    o = '{SEL_T,  SEL_Y, 1'b0, 1'b1, 1'b1, 1'b0, DEST_TY};
         5'd2:    o = '{SEL_T,  SEL_Z, 1'b0, 1'b1, 1'b1, 1'b0, DEST_TZ};
         5'd3:    o = '{SEL_TX, SEL_X, 1'b0, 1'b1, 1'b1, 1'b1, 5'd0};
         5'd4:    o = '{SEL_TX, SEL_Y, 1'b0, 1'b1, 1'b0, 1'b0, 5'd1};
         5'd5:    o = '{SEL_S,  SEL_Z, 1'b1, 1'b0, 1'b1, 1'b0, 5'd1};
         5'd6:    o = '{SEL_TX, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 5'd2};
         5'd7:    o = '{SEL_S,  SEL_Y, 1'b0, 1'b0, 1'b1, 1'b0, 5'd2};
         5'd8:    o = '{SEL_TX, SEL_Y, 1'b0, 1'b1, 1'b0, 1'b0, 5'd4};
         5'd9:    o = '{SEL_S,  SEL_Z, 1'b0, 1'b0, 1'b1, 1'b0, 5'd4};
         5'd10:   o = '{SEL_TY, SEL_Y, 1'b0, 1'b1, 1'b1, 1'b1, 5'd5};
         5'd11:   o = '{SEL_TY, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 5'd6};
         5'd12:   o = '{SEL_S,  SEL_X, 1'b1, 1'b0, 1'b1, 1'b0, 5'd6};
         5'd13:   o = '{SEL_TX, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 5'd8};
         5'd14:   o = '{SEL_S,  SEL_Y, 1'b1, 1'b0, 1'b1, 1'b0, 5'd8};
         5'd15:   o = '{SEL_TY, SEL_Z, 1'b0, 1'b1, 1'b0, 1'b0, 5'd9};
         5'd16:   o = '{SEL_S,  SEL_X, 1'b0, 1'b0, 1'b1, 1'b0, 5'd9};
         5'd17:   o = '{SEL_TZ, SEL_Z, 1'b0, 1'b1, 1'b1, 1'b1, 5'd10};
         default: o = '{SEL_T,  SEL_X, 1'b0, 1'b1, 1'b0, 1'b0, 5'd0};
      endcase
      return o;
   endfunction

   function automatic logic signed [33:0] cordic_atan(input logic [4:0] i);
      logic signed [33:0] a;
      case (i)
         5'd0:    a = 34'sd843314856;
         5'd1:    a = 34'sd497837829;
         5'd2:    a = 34'sd263043836;
         5'd3:    a = 34'sd133525158;
         5'd4:    a = 34'sd67021686;
         5'd5:    a = 34'sd33543515;
         5'd6:    a = 34'sd16775850;
         5'd7:    a = 34'sd8388437;
         5'd8:    a = 34'sd4194282;
         5'd9:    a = 34'sd2097149;
         5'd10:   a = 34'sd1048575;
         5'd11:   a = 34'sd524287;
         5'd12:   a = 34'sd262143;
         5'd13:   a = 34'sd131071;
         5'd14:   a = 34'sd65535;
         5'd15:   a = 34'sd32767;
         5'd16:   a = 34'sd16383;
         5'd17:   a = 34'sd8191;
         5'd18:   a = 34'sd4095;
         5'd19:   a = 34'sd2047;
         5'd20:   a = 34'sd1023;
         5'd21:   a = 34'sd511;
         5'd22:   a = 34'sd255;
         5'd23:   a = 34'sd127;
         5'd24:   a = 34'sd63;
         5'd25:   a = 34'sd31;
         5'd26:   a = 34'sd15;
         5'd27:   a = 34'sd8;
         5'd28:   a = 34'sd4;
         5'd29:   a = 34'sd2;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

endpackage

// File: hw/rtl/atmu_ctrl.sv
// ----------------------------------------------------------------------------
// atmu_ctrl
// Sequencer of the transform unit: steps the datapath through capture,
// matrix build, angle reduction, CORDIC, multiply-accumulate and row output.
// ----------------------------------------------------------------------------
module atmu_ctrl #(
   parameter int FRAC_BITS = atmu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [1:0]                req_row_select,
   output atmu_pkg::dp_cmd_type      cmd,
   input  atmu_pkg::dp_status_type   status
);

   localparam int ZW        = 49 - FRAC_BITS;
   localparam int RED_STEPS = (ZW > 34) ? ZW - 33 : 1;

   atmu_pkg::ctrl_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in, rowsel_ff, rowsel_in;
   logic       use_ff, use_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= atmu_pkg::S_IDLE;
         cnt_ff    <= '0;
         r_ff      <= '0;
         c_ff      <= '0;
         k_ff      <= '0;
         rowsel_ff <= '0;
         use_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         r_ff      <= r_in;
         c_ff      <= c_in;
         k_ff      <= k_in;
         rowsel_ff <= rowsel_in;
         use_ff    <= use_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      rowsel_in  = rowsel_ff;
      use_in     = use_ff;
      req_ready  = 1'b0;
      cmd.op     = atmu_pkg::OP_NONE;
      cmd.step   = cnt_ff;
      cmd.row    = r_ff;
      cmd.col    = c_ff;
      cmd.k      = k_ff;
      cmd.use_op = use_ff;
      cmd.rot    = 1'b0;
      case (state_ff)
         atmu_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op    = atmu_pkg::OP_CAPTURE;
               rowsel_in = req_row_select;
               r_in      = '0;
               c_in      = '0;
               k_in      = '0;
               cnt_in    = '0;
               use_in    = 1'b0;
               case (atmu_pkg::action_type'(req_action))
                  atmu_pkg::ACT_RESET:     state_in = atmu_pkg::S_IDENT;
                  atmu_pkg::ACT_SCALE:     state_in = atmu_pkg::S_SCALE;
                  atmu_pkg::ACT_TRANSLATE: state_in = atmu_pkg::S_TRANS;
                  atmu_pkg::ACT_ROTATE:    state_in = atmu_pkg::S_RED_INIT;
                  atmu_pkg::ACT_LOAD_ROW:  state_in = atmu_pkg::S_LOAD;
                  default:                 state_in = atmu_pkg::S_IDLE;
               endcase
            end
         end
         atmu_pkg::S_IDENT: begin
            cmd.op   = atmu_pkg::OP_IDENT;
            state_in = atmu_pkg::S_OUT;
         end
         atmu_pkg::S_SCALE: begin
            cmd.op   = atmu_pkg::OP_SCALE;
            state_in = atmu_pkg::S_PM_MUL;
         end
         atmu_pkg::S_TRANS: begin
            cmd.op   = atmu_pkg::OP_TRANS;
            state_in = atmu_pkg::S_PM_MUL;
         end
         atmu_pkg::S_LOAD: begin
            cmd.op = atmu_pkg::OP_LOAD_ROW;
            use_in = 1'b1;
            if (rowsel_ff == 2'd3) begin
               state_in = atmu_pkg::S_PM_MUL;
            end else begin
               state_in = atmu_pkg::S_IDLE;
            end
         end
         atmu_pkg::S_RED_INIT: begin
            cmd.op   = atmu_pkg::OP_RED_INIT;
            cnt_in   = 5'(RED_STEPS - 1);
            state_in = atmu_pkg::S_RED;
         end
         atmu_pkg::S_RED: begin
            cmd.op = atmu_pkg::OP_RED_STEP;
            if (cnt_ff == '0) begin
               state_in = atmu_pkg::S_CORDIC_INIT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         atmu_pkg::S_CORDIC_INIT: begin
            cmd.op   = atmu_pkg::OP_CORDIC_INIT;
            cnt_in   = '0;
            state_in = atmu_pkg::S_CORDIC;
         end
         atmu_pkg::S_CORDIC: begin
            cmd.op = atmu_pkg::OP_CORDIC_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(atmu_pkg::CORDIC_STEPS - 1)) begin
               state_in = atmu_pkg::S_CORDIC_FIN;
            end
         end
         atmu_pkg::S_CORDIC_FIN: begin
            cmd.op   = atmu_pkg::OP_CORDIC_FIN;
            cnt_in   = '0;
            state_in = atmu_pkg::S_ROT_MUL;
         end
         atmu_pkg::S_ROT_MUL: begin
            cmd.op   = atmu_pkg::OP_MUL;
            cmd.rot  = 1'b1;
            state_in = atmu_pkg::S_ROT_ACC;
         end
         atmu_pkg::S_ROT_ACC: begin
            cmd.op  = atmu_pkg::OP_ACC;
            cmd.rot = 1'b1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(atmu_pkg::ROT_STEPS - 1)) begin
               state_in = atmu_pkg::S_PM_MUL;
            end else begin
               state_in = atmu_pkg::S_ROT_MUL;
            end
         end
         atmu_pkg::S_PM_MUL: begin
            cmd.op   = atmu_pkg::OP_MUL;
            state_in = atmu_pkg::S_PM_ACC;
         end
         atmu_pkg::S_PM_ACC: begin
            cmd.op   = atmu_pkg::OP_ACC;
            k_in     = k_ff + 2'd1;
            state_in = atmu_pkg::S_PM_MUL;
            if (k_ff == 2'd3) begin
               c_in = c_ff + 2'd1;
               if (c_ff == 2'd3) begin
                  state_in = atmu_pkg::S_PM_ROW;
               end
            end
         end
         atmu_pkg::S_PM_ROW: begin
            cmd.op = atmu_pkg::OP_ROW_WRITE;
            r_in   = r_ff + 2'd1;
            cnt_in = '0;
            if (r_ff == 2'd3) begin
               state_in = atmu_pkg::S_OUT;
            end else begin
               state_in = atmu_pkg::S_PM_MUL;
            end
         end
         atmu_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.op = atmu_pkg::OP_OUT_LOAD;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff[1:0] == 2'd3) begin
                  state_in = atmu_pkg::S_IDLE;
               end
            end
         end
         default: state_in = atmu_pkg::S_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/atmu_datapath.sv
// ----------------------------------------------------------------------------
// atmu_datapath
// Matrix registers, angle reduction, CORDIC, shared multiplier with
// saturating accumulator, and the result output register.
// ----------------------------------------------------------------------------
module atmu_datapath #(
   parameter int FRAC_BITS = atmu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  atmu_pkg::dp_cmd_type      cmd,
   output atmu_pkg::dp_status_type   status,
   input  logic [1:0]                req_row_select,
   input  logic signed [31:0]        req_value_0,
   input  logic signed [31:0]        req_value_1,
   input  logic signed [31:0]        req_value_2,
   input  logic signed [31:0]        req_value_3,
   input  logic signed [18:0]        req_angle,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_row_index,
   output logic signed [31:0]        rsp_elem_0,
   output logic signed [31:0]        rsp_elem_1,
   output logic signed [31:0]        rsp_elem_2,
   output logic signed [31:0]        rsp_elem_3,
   output logic                      rsp_last
);

   localparam int ZW  = 49 - FRAC_BITS;
   localparam int CW  = (ZW > 34) ? ZW : 34;
   localparam int NSH = 30 - FRAC_BITS;
   localparam int TW  = 64 - FRAC_BITS;
   localparam int AW  = TW + 3;
   localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] I32_MAX = 32'h7fffffff;
   localparam logic signed [31:0] I32_MIN = 32'h80000000;
   localparam logic signed [33:0] HALF    = 34'sd1 <<< (NSH - 1);

   logic signed [31:0] cur_ff [4][4];
   logic signed [31:0] tmat_ff [16];
   logic signed [31:0] opmat_ff [16];
   logic signed [31:0] rowbuf_ff [4];
   logic signed [31:0] v_ff [4];
   logic [1:0]         rowsel_ff;
   logic signed [18:0] angle_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff, c_ff, s_ff, t_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [CW-1:0]      rem_ff;
   logic               zneg_ff, flip_ff;
   logic signed [63:0] prod_ff;
   logic signed [AW-1:0] acc_ff;

   logic                 ov_ff;
   logic [1:0]           orow_ff;
   logic signed [31:0]   oelem_ff [4];
   logic                 olast_ff;

   // operand selection
   logic [1:0]           cur_sel;
   logic signed [31:0]   cur_rd [4];
   logic [3:0]           b_idx;
   logic signed [31:0]   a_pm, b_pm, a_rot, b_rot, mul_a, mul_b;
   atmu_pkg::rot_op_type rop;

   assign cur_sel = (cmd.op == atmu_pkg::OP_OUT_LOAD) ? cmd.step[1:0] : cmd.row;
   assign cur_rd  = cur_ff[cur_sel];
   assign b_idx   = {cmd.k, cmd.col};
   assign a_pm    = cur_rd[cmd.k];
   assign b_pm    = cmd.use_op ? opmat_ff[b_idx] : tmat_ff[b_idx];
   assign rop     = atmu_pkg::rot_op(cmd.step);

   always_comb begin
      case (rop.a)
         atmu_pkg::SEL_T:  a_rot = t_ff;
         atmu_pkg::SEL_TX: a_rot = tx_ff;
         atmu_pkg::SEL_TY: a_rot = ty_ff;
         atmu_pkg::SEL_TZ: a_rot = tz_ff;
         atmu_pkg::SEL_S:  a_rot = s_ff;
         default:          a_rot = t_ff;
      endcase
      case (rop.b)
         atmu_pkg::SEL_X: b_rot = v_ff[0];
         atmu_pkg::SEL_Y: b_rot = v_ff[1];
         atmu_pkg::SEL_Z: b_rot = v_ff[2];
         default:         b_rot = v_ff[0];
      endcase
   end

   assign mul_a = cmd.rot ? a_rot : a_pm;
   assign mul_b = cmd.rot ? b_rot : b_pm;

   // accumulate
   logic signed [TW-1:0] term;
   logic signed [AW-1:0] base, acc_sum;
   logic signed [31:0]   sat_val;
   logic                 t_first, t_last, t_neg, t_addc;

   assign term    = prod_ff[63:FRAC_BITS];
   assign t_first = cmd.rot ? rop.first : (cmd.k == 2'd0);
   assign t_last  = cmd.rot ? rop.last : (cmd.k == 2'd3);
   assign t_neg   = cmd.rot & rop.neg;
   assign t_addc  = cmd.rot & rop.add_c;

   always_comb begin
      if (t_first) begin
         base = t_addc ? AW'(c_ff) : '0;
      end else begin
         base = acc_ff;
      end
      acc_sum = t_neg ? base - AW'(term) : base + AW'(term);
      if (acc_sum > AW'(I32_MAX)) begin
         sat_val = I32_MAX;
      end else if (acc_sum < AW'(I32_MIN)) begin
         sat_val = I32_MIN;
      end else begin
         sat_val = acc_sum[31:0];
      end
   end

   // angle reduction and CORDIC
   logic signed [ZW-1:0] z_full;
   logic [CW-1:0]        z_mag, red_cmp;
   logic signed [33:0]   zr0, zr1, zr2, dx, dy, atan, xf, yf;

   assign z_full  = ZW'(angle_ff) <<< NSH;
   assign z_mag   = CW'($unsigned(z_full[ZW-1] ? -z_full : z_full));
   assign red_cmp = CW'(atmu_pkg::TWO_PI_MAG) << cmd.step;
   assign zr0     = zneg_ff ? -{1'b0, rem_ff[32:0]} : {1'b0, rem_ff[32:0]};
   assign dx      = y_ff >>> cmd.step;
   assign dy      = x_ff >>> cmd.step;
   assign atan    = atmu_pkg::cordic_atan(cmd.step);
   assign xf      = flip_ff ? -x_ff : x_ff;
   assign yf      = flip_ff ? -y_ff : y_ff;

   always_comb begin
      zr1 = zr0;
      if (zr0 > atmu_pkg::Q30_PI) begin
         zr1 = zr0 - atmu_pkg::Q30_TWO_PI;
      end else if (zr0 < -atmu_pkg::Q30_PI) begin
         zr1 = zr0 + atmu_pkg::Q30_TWO_PI;
      end
      zr2 = zr1;
      if (zr1 > atmu_pkg::Q30_HALF_PI) begin
         zr2 = zr1 - atmu_pkg::Q30_PI;
      end else if (zr1 < -atmu_pkg::Q30_HALF_PI) begin
         zr2 = zr1 + atmu_pkg::Q30_PI;
      end
   end

   logic signed [33:0] c_rnd, s_rnd;
   assign c_rnd = (xf + HALF) >>> NSH;
   assign s_rnd = (yf + HALF) >>> NSH;

   // current matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               cur_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (cmd.op == atmu_pkg::OP_IDENT) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               cur_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else if (cmd.op == atmu_pkg::OP_ROW_WRITE) begin
         cur_ff[cmd.row] <= rowbuf_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         atmu_pkg::OP_CAPTURE: begin
            v_ff[0]   <= req_value_0;
            v_ff[1]   <= req_value_1;
            v_ff[2]   <= req_value_2;
            v_ff[3]   <= req_value_3;
            rowsel_ff <= req_row_select;
            angle_ff  <= req_angle;
         end
         atmu_pkg::OP_SCALE: begin
            for (int i = 0; i < 16; i++) begin
               tmat_ff[i] <= (i == 0)  ? v_ff[0] :
                             (i == 5)  ? v_ff[1] :
                             (i == 10) ? v_ff[2] :
                             (i == 15) ? ONE : '0;
            end
         end
         atmu_pkg::OP_TRANS: begin
            for (int i = 0; i < 16; i++) begin
               tmat_ff[i] <= (i == 3)  ? v_ff[0] :
                             (i == 7)  ? v_ff[1] :
                             (i == 11) ? v_ff[2] :
                             (i % 5 == 0) ? ONE : '0;
            end
         end
         atmu_pkg::OP_LOAD_ROW: begin
            for (int j = 0; j < 4; j++) begin
               opmat_ff[{rowsel_ff, 2'(j)}] <= v_ff[j];
            end
         end
         atmu_pkg::OP_RED_INIT: begin
            rem_ff  <= z_mag;
            zneg_ff <= z_full[ZW-1];
         end
         atmu_pkg::OP_RED_STEP: begin
            if (rem_ff >= red_cmp) begin
               rem_ff <= rem_ff - red_cmp;
            end
         end
         atmu_pkg::OP_CORDIC_INIT: begin
            z_ff    <= zr2;
            flip_ff <= (zr1 > atmu_pkg::Q30_HALF_PI) || (zr1 < -atmu_pkg::Q30_HALF_PI);
            x_ff    <= atmu_pkg::Q30_GAIN_INV;
            y_ff    <= '0;
         end
         atmu_pkg::OP_CORDIC_STEP: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - atan;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + atan;
            end
         end
         atmu_pkg::OP_CORDIC_FIN: begin
            c_ff <= c_rnd[31:0];
            s_ff <= s_rnd[31:0];
            t_ff <= ONE - c_rnd[31:0];
            for (int i = 0; i < 16; i++) begin
               tmat_ff[i] <= (i == 15) ? ONE : '0;
            end
         end
         atmu_pkg::OP_MUL: begin
            prod_ff <= mul_a * mul_b;
         end
         atmu_pkg::OP_ACC: begin
            acc_ff <= acc_sum;
            if (t_last) begin
               if (!cmd.rot) begin
                  rowbuf_ff[cmd.col] <= sat_val;
               end else if (rop.dest == atmu_pkg::DEST_TX) begin
                  tx_ff <= sat_val;
               end else if (rop.dest == atmu_pkg::DEST_TY) begin
                  ty_ff <= sat_val;
               end else if (rop.dest == atmu_pkg::DEST_TZ) begin
                  tz_ff <= sat_val;
               end else begin
                  tmat_ff[rop.dest[3:0]] <= sat_val;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.op == atmu_pkg::OP_OUT_LOAD) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == atmu_pkg::OP_OUT_LOAD) begin
         orow_ff  <= cmd.step[1:0];
         oelem_ff <= cur_rd;
         olast_ff <= (cmd.step[1:0] == 2'd3);
      end
   end

   assign status.out_free = !ov_ff || rsp_ready;
   assign rsp_valid     = ov_ff;
   assign rsp_row_index = orow_ff;
   assign rsp_elem_0    = oelem_ff[0];
   assign rsp_elem_1    = oelem_ff[1];
   assign rsp_elem_2    = oelem_ff[2];
   assign rsp_elem_3    = oelem_ff[3];
   assign rsp_last      = olast_ff;

endmodule

// File: hw/rtl/affine_transform_matrix_unit_core.sv
// ----------------------------------------------------------------------------
// affine_transform_matrix_unit_core
// 4x4 fixed-point transform: scale, translate, rotate, general post-multiply;
// each update but a load of rows 0 to 2 returns the matrix as four rows.
// ----------------------------------------------------------------------------
// One item is worked at a time. A single 32x32 multiplier is shared: a
// post-multiply takes 64 products plus 4 row writes. Rotate adds the
// angle reduction, the CORDIC iterations and 18 products for the rotation
// terms. The four rows of a result leave at one per cycle while rsp_ready
// is high.
module affine_transform_matrix_unit_core #(
   parameter int FRAC_BITS = atmu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [1:0]         req_row_select,
   input  logic signed [31:0] req_value_0,
   input  logic signed [31:0] req_value_1,
   input  logic signed [31:0] req_value_2,
   input  logic signed [31:0] req_value_3,
   input  logic signed [18:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_elem_0,
   output logic signed [31:0] rsp_elem_1,
   output logic signed [31:0] rsp_elem_2,
   output logic signed [31:0] rsp_elem_3,
   output logic               rsp_last
);

   atmu_pkg::dp_cmd_type    cmd;
   atmu_pkg::dp_status_type status;

   atmu_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_row_select (req_row_select),
      .cmd            (cmd),
      .status         (status)
   );

   atmu_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_row_select (req_row_select),
      .req_value_0    (req_value_0),
      .req_value_1    (req_value_1),
      .req_value_2    (req_value_2),
      .req_value_3    (req_value_3),
      .req_angle      (req_angle),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_row_index  (rsp_row_index),
      .rsp_elem_0     (rsp_elem_0),
      .rsp_elem_1     (rsp_elem_1),
      .rsp_elem_2     (rsp_elem_2),
      .rsp_elem_3     (rsp_elem_3),
      .rsp_last       (rsp_last)
   );

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_row_index == 2'd3)))
      else $error("last flag does not match row index");

   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap between result rows");

   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |-> !req_ready)
      else $error("input taken while rows remain");

endmodule
